// ===== hdl/i2p_pkg.sv =====
// Shared types, constants and lookup functions of the infix-to-postfix converter.
`default_nettype none

package i2p_pkg;

  localparam int STACK_DEPTH = 32;
  localparam int CNT_W       = $clog2(STACK_DEPTH + 1);
  localparam int IDX_W       = $clog2(STACK_DEPTH);
  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  // Stack entry codes
  localparam logic [2:0] CODE_OPEN = 3'd0;
  localparam logic [2:0] CODE_ADD  = 3'd1;
  localparam logic [2:0] CODE_SUB  = 3'd2;
  localparam logic [2:0] CODE_MUL  = 3'd3;
  localparam logic [2:0] CODE_DIV  = 3'd4;
  localparam logic [2:0] CODE_POW  = 3'd5;

  localparam logic [7:0] CH_OPEN  = 8'h28;
  localparam logic [7:0] CH_CLOSE = 8'h29;
  localparam logic [7:0] CH_MUL   = 8'h2A;
  localparam logic [7:0] CH_ADD   = 8'h2B;
  localparam logic [7:0] CH_SUB   = 8'h2D;
  localparam logic [7:0] CH_DIV   = 8'h2F;
  localparam logic [7:0] CH_POW   = 8'h5E;

  typedef enum logic [2:0] {
    K_ALNUM,
    K_OPEN,
    K_CLOSE,
    K_OPER,
    K_END
  } kind_e;

  typedef struct packed {
    kind_e      kind;
    logic [7:0] sym;
    logic [2:0] code;
  } cmd_t;

  function automatic logic [7:0] code_char(input logic [2:0] code);
    case (code)
      CODE_OPEN: code_char = CH_OPEN;
      CODE_ADD:  code_char = CH_ADD;
      CODE_SUB:  code_char = CH_SUB;
      CODE_MUL:  code_char = CH_MUL;
      CODE_DIV:  code_char = CH_DIV;
      CODE_POW:  code_char = CH_POW;
      default:   code_char = 8'h00;
    endcase
  endfunction

  function automatic logic [1:0] code_prec(input logic [2:0] code);
    case (code)
      CODE_ADD, CODE_SUB: code_prec = 2'd1;
      CODE_MUL, CODE_DIV: code_prec = 2'd2;
      CODE_POW:           code_prec = 2'd3;
      default:            code_prec = 2'd0;
    endcase
  endfunction

endpackage

`default_nettype wire

// ===== hdl/infix_to_postfix_converter.sv =====
// Infix-to-postfix converter top level: front end, command queue and stack engine.
//
// Input channel: one ASCII character per word (symbol_i), or an end mark (is_end_i).
// A word moves when in_valid_i is high and in_stall_o is low. Characters other
// than letters, digits, parens and + - * / ^ are dropped without a result.
// Output channel: one postfix character per word, with last_o on the final word
// that an input causes; the end mark flushes the stack and closes with a
// terminator word (end_of_expr_o) carrying the overflow and unmatched-')' flags.
// A word moves when out_valid_o is high and out_stall_i is low.
// Flow: an accepted input is written into the command queue, and the stack engine
// reads it from there and registers the output word. The stack engine does one
// stack access per cycle, but an access that emits a word waits while out_stall_i
// holds the output word; each popped operator is a stack access of its own.
// While out_stall_i is high the output word holds; the two-entry queue holds the
// word in progress and one more, then in_stall_o rises until the engine retires one.
// Reset clears the stack count, the flags and all valid state at once.
`default_nettype none

module infix_to_postfix_converter (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       in_valid_i,
  output logic            in_stall_o,
  input  wire logic [7:0] symbol_i,
  input  wire logic       is_end_i,
  output logic            out_valid_o,
  input  wire logic       out_stall_i,
  output logic [7:0]      out_symbol_o,
  output logic            end_of_expr_o,
  output logic            last_o,
  output logic            overflow_seen_o,
  output logic            unmatched_close_o
);
  import i2p_pkg::*;

  logic wr_valid, q_full, rd_valid, rd_pop;
  cmd_t wr_cmd, rd_cmd;

  i2p_front u_front (
    .in_valid_i (in_valid_i),
    .symbol_i   (symbol_i),
    .is_end_i   (is_end_i),
    .q_full_i   (q_full),
    .in_stall_o (in_stall_o),
    .wr_valid_o (wr_valid),
    .wr_cmd_o   (wr_cmd)
  );

  i2p_queue u_queue (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .wr_valid_i (wr_valid),
    .wr_cmd_i   (wr_cmd),
    .full_o     (q_full),
    .rd_valid_o (rd_valid),
    .rd_cmd_o   (rd_cmd),
    .rd_pop_i   (rd_pop)
  );

  i2p_back u_back (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .rd_valid_i        (rd_valid),
    .rd_cmd_i          (rd_cmd),
    .rd_pop_o          (rd_pop),
    .out_valid_o       (out_valid_o),
    .out_stall_i       (out_stall_i),
    .out_symbol_o      (out_symbol_o),
    .end_of_expr_o     (end_of_expr_o),
    .last_o            (last_o),
    .overflow_seen_o   (overflow_seen_o),
    .unmatched_close_o (unmatched_close_o)
  );

endmodule

`default_nettype wire

// ===== hdl/i2p_front.sv =====
// Input front end: classifies each accepted character into a stack command.
`default_nettype none

module i2p_front (
  input  wire logic          in_valid_i,
  input  wire logic [7:0]    symbol_i,
  input  wire logic          is_end_i,
  input  wire logic          q_full_i,
  output logic               in_stall_o,
  output logic               wr_valid_o,
  output i2p_pkg::cmd_t      wr_cmd_o
);
  import i2p_pkg::*;

  logic keep;

  assign in_stall_o = q_full_i;

  always_comb begin
    keep             = 1'b1;
    wr_cmd_o.sym     = symbol_i;
    wr_cmd_o.code    = CODE_OPEN;
    wr_cmd_o.kind    = K_ALNUM;
    if (is_end_i) begin
      wr_cmd_o.kind = K_END;
    end else if (symbol_i inside {[8'h30:8'h39], [8'h41:8'h5A], [8'h61:8'h7A]}) begin
      wr_cmd_o.kind = K_ALNUM;
    end else begin
      case (symbol_i)
        CH_OPEN:  wr_cmd_o.kind = K_OPEN;
        CH_CLOSE: wr_cmd_o.kind = K_CLOSE;
        CH_ADD: begin
          wr_cmd_o.kind = K_OPER;
          wr_cmd_o.code = CODE_ADD;
        end
        CH_SUB: begin
          wr_cmd_o.kind = K_OPER;
          wr_cmd_o.code = CODE_SUB;
        end
        CH_MUL: begin
          wr_cmd_o.kind = K_OPER;
          wr_cmd_o.code = CODE_MUL;
        end
        CH_DIV: begin
          wr_cmd_o.kind = K_OPER;
          wr_cmd_o.code = CODE_DIV;
        end
        CH_POW: begin
          wr_cmd_o.kind = K_OPER;
          wr_cmd_o.code = CODE_POW;
        end
        // drop anything else
        default: keep = 1'b0;
      endcase
    end
  end

  assign wr_valid_o = in_valid_i && !q_full_i && keep;

endmodule

`default_nettype wire

// ===== hdl/i2p_queue.sv =====
// Short command queue between the front end and the stack engine.
`default_nettype none

module i2p_queue (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          wr_valid_i,
  input  wire i2p_pkg::cmd_t wr_cmd_i,
  output logic               full_o,
  output logic               rd_valid_o,
  output i2p_pkg::cmd_t      rd_cmd_o,
  input  wire logic          rd_pop_i
);
  import i2p_pkg::*;

  cmd_t              mem_q [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wptr_q, wptr_d, rptr_q, rptr_d;
  logic [QCNT_W-1:0] cnt_q, cnt_d;
  logic              do_rd;

  assign full_o     = (cnt_q == QCNT_W'(QUEUE_DEPTH));
  assign rd_valid_o = (cnt_q != '0);
  assign rd_cmd_o   = mem_q[rptr_q];
  assign do_rd      = rd_pop_i && rd_valid_o;

  always_comb begin
    wptr_d = wptr_q;
    rptr_d = rptr_q;
    cnt_d  = cnt_q;
    if (wr_valid_i) begin
      wptr_d = (wptr_q == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wptr_q + QPTR_W'(1);
    end
    if (do_rd) begin
      rptr_d = (rptr_q == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rptr_q + QPTR_W'(1);
    end
    if (wr_valid_i && !do_rd) begin
      cnt_d = cnt_q + QCNT_W'(1);
    end else if (!wr_valid_i && do_rd) begin
      cnt_d = cnt_q - QCNT_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q  <= '0;
    end else begin
      wptr_q <= wptr_d;
      rptr_q <= rptr_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_valid_i) begin
      mem_q[wptr_q] <= wr_cmd_i;
    end
  end

endmodule

`default_nettype wire

// ===== hdl/i2p_back.sv =====
// Stack engine: runs queued commands on the operator stack and drives the output word.
`default_nettype none

module i2p_back (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          rd_valid_i,
  input  wire i2p_pkg::cmd_t rd_cmd_i,
  output logic               rd_pop_o,
  output logic               out_valid_o,
  input  wire logic          out_stall_i,
  output logic [7:0]         out_symbol_o,
  output logic               end_of_expr_o,
  output logic               last_o,
  output logic               overflow_seen_o,
  output logic               unmatched_close_o
);
  import i2p_pkg::*;

  logic [2:0]       stack_q [STACK_DEPTH];
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic [2:0]       top_q, top_d;
  logic             ovf_q, ovf_d, unm_q, unm_d;
  logic             oval_q, oval_d;

  logic             out_can, has, at_one, full;
  logic [2:0]       sec;
  logic             emit, e_end, e_last, e_ovf, e_unm;
  logic [7:0]       e_sym;
  logic             push, pop;
  logic [2:0]       push_code;

  assign out_can = !oval_q || !out_stall_i;
  assign has     = (cnt_q != '0);
  assign at_one  = (cnt_q == CNT_W'(1));
  assign full    = (cnt_q >= CNT_W'(STACK_DEPTH));
  // entry just below the top; only meaningful when more than one entry is stacked
  assign sec     = stack_q[IDX_W'(cnt_q - CNT_W'(2))];

  always_comb begin
    rd_pop_o  = 1'b0;
    emit      = 1'b0;
    e_sym     = 8'h00;
    e_end     = 1'b0;
    e_last    = 1'b0;
    e_ovf     = 1'b0;
    e_unm     = 1'b0;
    push      = 1'b0;
    pop       = 1'b0;
    push_code = rd_cmd_i.code;
    ovf_d     = ovf_q;
    unm_d     = unm_q;
    if (rd_valid_i) begin
      case (rd_cmd_i.kind)
        K_ALNUM: begin
          if (out_can) begin
            emit     = 1'b1;
            e_sym    = rd_cmd_i.sym;
            e_last   = 1'b1;
            rd_pop_o = 1'b1;
          end
        end
        K_OPEN: begin
          push_code = CODE_OPEN;
          if (full) ovf_d = 1'b1;
          else push = 1'b1;
          rd_pop_o = 1'b1;
        end
        K_CLOSE: begin
          if (!has) begin
            unm_d    = 1'b1;
            rd_pop_o = 1'b1;
          end else if (top_q == CODE_OPEN) begin
            pop      = 1'b1;
            rd_pop_o = 1'b1;
          end else if (out_can) begin
            emit   = 1'b1;
            e_sym  = code_char(top_q);
            e_last = at_one || (sec == CODE_OPEN);
            pop    = 1'b1;
          end
        end
        K_OPER: begin
          if (has && (code_prec(top_q) >= code_prec(rd_cmd_i.code))) begin
            if (out_can) begin
              emit   = 1'b1;
              e_sym  = code_char(top_q);
              e_last = at_one || (code_prec(sec) < code_prec(rd_cmd_i.code));
              pop    = 1'b1;
            end
          end else begin
            if (full) ovf_d = 1'b1;
            else push = 1'b1;
            rd_pop_o = 1'b1;
          end
        end
        K_END: begin
          if (out_can) begin
            emit = 1'b1;
            if (has) begin
              e_sym = code_char(top_q);
              pop   = 1'b1;
            end else begin
              // terminator carries the sticky flags, then clears them
              e_end    = 1'b1;
              e_last   = 1'b1;
              e_ovf    = ovf_q;
              e_unm    = unm_q;
              ovf_d    = 1'b0;
              unm_d    = 1'b0;
              rd_pop_o = 1'b1;
            end
          end
        end
        default: rd_pop_o = 1'b1;
      endcase
    end
  end

  always_comb begin
    cnt_d = cnt_q;
    top_d = top_q;
    if (push) begin
      cnt_d = cnt_q + CNT_W'(1);
      top_d = push_code;
    end else if (pop) begin
      cnt_d = cnt_q - CNT_W'(1);
      top_d = sec;
    end
  end

  always_comb begin
    oval_d = oval_q;
    if (emit) oval_d = 1'b1;
    else if (!out_stall_i) oval_d = 1'b0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      ovf_q  <= 1'b0;
      unm_q  <= 1'b0;
      oval_q <= 1'b0;
    end else begin
      cnt_q  <= cnt_d;
      ovf_q  <= ovf_d;
      unm_q  <= unm_d;
      oval_q <= oval_d;
    end
  end

  always_ff @(posedge clk_i) begin
    top_q <= top_d;
    if (push) begin
      stack_q[cnt_q[IDX_W-1:0]] <= push_code;
    end
    if (emit) begin
      out_symbol_o      <= e_sym;
      end_of_expr_o     <= e_end;
      last_o            <= e_last;
      overflow_seen_o   <= e_ovf;
      unmatched_close_o <= e_unm;
    end
  end

  assign out_valid_o = oval_q;

endmodule

`default_nettype wire
